FILE: design/cwmf_pkg.sv
// types and constants of the clipped window median filter
// no dependencies; imported by all cwmf modules and the top level

package cwmf_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // request kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // field widths fixed by the interface
    localparam int RADIUS_W   = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       row_end;
        logic       frame_end;
    } t_out_beat;

    // one slot of the sorting chain; an empty slot counts as above every pixel
    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GATHER,
        ST_FLUSH,
        ST_EMIT
    } t_state;

endpackage

FILE: design/clipped_window_median_filter.sv
// top level of the clipped window median filter: line store, counters, sequencer
// depends on cwmf_pkg and cwmf_chain
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready   | i_in_data  (t_in_beat)
//  output   | o_out_valid / i_out_ready | o_out_data (t_out_beat)
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// an input beat with no result passes the idle and check steps; one with a
// result also passes gather, flush and emit; the line store's single read port
// feeds the n pixels of the clipped window (up to (2*MAX_RADIUS+1)^2) one a
// cycle into the sorting chain. reset is synchronous, active low, no clearing
// pass. a stalled output holds the sequencer in emit until the slot frees.

module clipped_window_median_filter #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cwmf_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cwmf_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [cwmf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cwmf_pkg::*;

    localparam int WIN  = 2 * MAX_RADIUS + 1;
    localparam int WIN2 = WIN * WIN;
    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int RGW  = $clog2(RING);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int NW   = $clog2(WIN2 + 1);
    localparam int NI   = $clog2(WIN2);

    // configuration
    logic [RADIUS_W-1:0] r_radius;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // frame position
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [CW-1:0]    r_in_col, r_out_col;
    logic [RGW-1:0]   r_in_ring, r_out_ring;
    logic             r_in_done;

    // window walk
    logic [ROW_W-1:0] r_y, r_y1;
    logic [CW-1:0]    r_x, r_x0, r_x1;
    logic [RGW-1:0]   r_ring;
    logic [NW-1:0]    r_n;
    logic             r_rd_vld;
    logic [7:0]       r_rd_data;

    t_state r_state, n_state;

    t_out_beat r_out;
    logic      r_out_valid;

    logic [7:0] mem [RING][MAX_WIDTH];

    logic             w_in_acc, w_emit, w_ready;
    logic [RW-1:0]    w_r;
    logic [CW-1:0]    w_w_m1;
    logic [ROW_W-1:0] w_h_m1;
    logic [ROW_W:0]   w_sum_r;
    logic [CW:0]      w_sum_c;
    logic [ROW_W-1:0] w_last_r, w_y0;
    logic [CW-1:0]    w_last_c, w_x0;
    logic [RW-1:0]    w_dy;
    logic [RGW:0]     w_ring_wrap;
    logic [RGW-1:0]   w_ring0;
    logic             w_row_end, w_frame_end;
    logic [7:0]       w_median;

    // effective configuration
    always_comb begin
        w_r = (int'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);
        if (r_width == '0) begin
            w_w_m1 = '0;
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_w_m1 = CW'(r_width - 11'd1);
        end
        if (r_height == '0) begin
            w_h_m1 = '0;
        end else if (int'(r_height) > MAX_HEIGHT) begin
            w_h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            w_h_m1 = ROW_W'(r_height - 13'd1);
        end
    end

    // window bounds and readiness of the next output
    always_comb begin
        w_sum_r  = {1'b0, r_out_row} + (ROW_W+1)'(w_r);
        w_sum_c  = {1'b0, r_out_col} + (CW+1)'(w_r);
        w_last_r = (w_sum_r > {1'b0, w_h_m1}) ? w_h_m1 : w_sum_r[ROW_W-1:0];
        w_last_c = (w_sum_c > {1'b0, w_w_m1}) ? w_w_m1 : w_sum_c[CW-1:0];
        w_y0 = (r_out_row >= ROW_W'(w_r)) ? (r_out_row - ROW_W'(w_r)) : '0;
        w_x0 = (r_out_col >= CW'(w_r)) ? (r_out_col - CW'(w_r)) : '0;
        w_dy = RW'(r_out_row - w_y0);
        w_ring_wrap = {1'b0, r_out_ring} + (RGW+1)'(RING) - (RGW+1)'(w_dy);
        w_ring0 = (r_out_ring >= RGW'(w_dy)) ? (r_out_ring - RGW'(w_dy))
                                             : w_ring_wrap[RGW-1:0];
        w_ready = r_in_done || (r_in_row > w_last_r)
                  || ((r_in_row == w_last_r) && (r_in_col > w_last_c));
        w_row_end   = (r_out_col >= w_w_m1);
        w_frame_end = w_row_end && (r_out_row >= w_h_m1);
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_emit     = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_CHECK;
            ST_CHECK:  n_state = w_ready ? ST_GATHER : ST_IDLE;
            ST_GATHER: if ((r_x == r_x1) && (r_y == r_y1)) n_state = ST_FLUSH;
            ST_FLUSH:  n_state = ST_EMIT;
            ST_EMIT:   if (w_emit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.req_type == REQ_PIXEL) && !r_in_done) begin
            mem[r_in_ring][r_in_col] <= i_in_data.pixel_in;
        end
        r_rd_data <= mem[r_ring][r_x];
    end

    // configuration, frame counters and window walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_W'(1);
            r_width     <= WIDTH_W'(640);
            r_height    <= HEIGHT_W'(480);
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_ring   <= '0;
            r_in_done   <= 1'b0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_ring  <= '0;
            r_n         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_GATHER);
            // output slot: a new beat replaces the one taken this cycle
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_RADIUS || i_cfg_idx == CFG_WIDTH
                             || i_cfg_idx == CFG_HEIGHT)) begin
                unique case (i_cfg_idx)
                    CFG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                    default:    r_height <= i_cfg_data[HEIGHT_W-1:0];
                endcase
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_ring  <= '0;
                r_in_done  <= 1'b0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_ring <= '0;
            end else begin
                // advance the source position
                if (w_in_acc && (i_in_data.req_type == REQ_PIXEL) && !r_in_done) begin
                    if (r_in_col >= w_w_m1) begin
                        r_in_col <= '0;
                        if (r_in_row >= w_h_m1) begin
                            r_in_row  <= '0;
                            r_in_ring <= '0;
                            r_in_done <= 1'b1;
                        end else begin
                            r_in_row  <= r_in_row + 1'b1;
                            r_in_ring <= (r_in_ring == RGW'(RING - 1)) ? '0
                                                                       : r_in_ring + 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                // step the output position
                if (w_emit) begin
                    if (w_frame_end) begin
                        r_in_row   <= '0;
                        r_in_col   <= '0;
                        r_in_ring  <= '0;
                        r_in_done  <= 1'b0;
                        r_out_row  <= '0;
                        r_out_col  <= '0;
                        r_out_ring <= '0;
                    end else if (w_row_end) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + 1'b1;
                        r_out_ring <= (r_out_ring == RGW'(RING - 1)) ? '0
                                                                     : r_out_ring + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
            // load the walk from the window bounds
            if (r_state == ST_CHECK) begin
                r_n <= '0;
            end
            // one read per cycle over the clipped window
            if (r_state == ST_GATHER) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // walk coordinates and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_y    <= w_y0;
            r_y1   <= w_last_r;
            r_x    <= w_x0;
            r_x0   <= w_x0;
            r_x1   <= w_last_c;
            r_ring <= w_ring0;
        end else if (r_state == ST_GATHER) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                if (r_y != r_y1) begin
                    r_y    <= r_y + 1'b1;
                    r_ring <= (r_ring == RGW'(RING - 1)) ? '0 : r_ring + 1'b1;
                end
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (w_emit) begin
            r_out.pixel_out <= w_median;
            r_out.row_end   <= w_row_end;
            r_out.frame_end <= w_frame_end;
        end
    end

    // sorting chain, rank floor(n/2)
    cwmf_chain #(
        .DEPTH (WIN2)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (r_state == ST_CHECK),
        .i_ins    (r_rd_vld),
        .i_pixel  (r_rd_data),
        .i_sel    (NI'(r_n >> 1)),
        .o_median (w_median)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a result appears only from the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("output valid rose outside the emit step");

    // the window never holds more than the full square
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(WIN2))
        else $error("window count over the square size");

    // the walk stays inside its bounds
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GATHER) |-> ((r_x <= r_x1) && (r_y <= r_y1)))
        else $error("window walk out of bounds");

    // no source beat taken while a window is being read
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GATHER || r_state == ST_FLUSH) |-> !o_in_ready)
        else $error("input taken during window read");

endmodule

FILE: design/cwmf_cell.sv
// one slot of the insertion sorting chain
// depends on cwmf_pkg

module cwmf_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_ins,
    input  logic [7:0]      i_pixel,
    input  cwmf_pkg::t_cell i_prev_cell,
    input  logic            i_prev_lt,
    output cwmf_pkg::t_cell o_cell,
    output logic            o_lt
);
    import cwmf_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    // new pixel sorts before this slot
    assign o_lt = i_ins && (!r_cell.valid || (i_pixel < r_cell.value));

    // shift right when the pixel lands to the left, take it when it lands here
    always_comb begin
        n_cell = r_cell;
        if (o_lt) begin
            if (i_prev_lt) begin
                n_cell = i_prev_cell;
            end else begin
                n_cell.valid = 1'b1;
                n_cell.value = i_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cell.valid <= 1'b0;
            r_cell.value <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: design/cwmf_chain.sv
// row of sorting cells with rank select
// depends on cwmf_pkg and cwmf_cell

module cwmf_chain #(
    parameter int DEPTH = 49
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_ins,
    input  logic [7:0]               i_pixel,
    input  logic [$clog2(DEPTH)-1:0] i_sel,
    output logic [7:0]               o_median
);
    import cwmf_pkg::*;

    t_cell w_cell [DEPTH];
    logic  w_lt   [DEPTH];

    // cells in ascending order, each looking at its left neighbour
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            cwmf_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_clear     (i_clear),
                .i_ins       (i_ins),
                .i_pixel     (i_pixel),
                .i_prev_cell ('0),
                .i_prev_lt   (1'b0),
                .o_cell      (w_cell[k]),
                .o_lt        (w_lt[k])
            );
        end else begin : g_rest
            cwmf_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_clear     (i_clear),
                .i_ins       (i_ins),
                .i_pixel     (i_pixel),
                .i_prev_cell (w_cell[k-1]),
                .i_prev_lt   (w_lt[k-1]),
                .o_cell      (w_cell[k]),
                .o_lt        (w_lt[k])
            );
        end
    end

    // value at the requested rank
    assign o_median = w_cell[i_sel].value;

endmodule

FILE: bench/clipped_window_median_filter_tb.sv
// self-checking bench for the clipped window median filter
// depends on cwmf_pkg and the clipped_window_median_filter top level
`timescale 1ns / 100ps

module clipped_window_median_filter_tb;
    import cwmf_pkg::*;

    localparam int RING      = 8;
    localparam int MAXW      = 1024;
    localparam int SETTLE    = 80;
    localparam int CYCLE_CAP = 4000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_beat             o_out_data;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    clipped_window_median_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // pending input beats and expected medians
    t_in_beat  beat_q[$];
    t_out_beat median_q[$];
    int        beats_owed;
    int        send_idle;
    int        recv_stall;
    bit        failed;
    int        cycles;
    int        items;

    // shadow of the filter state
    logic [7:0] line_mem [RING][MAXW];
    int  sh_radius, sh_width, sh_height;
    int  row_in, col_in, row_out, col_out;
    bit  frame_in;

    function automatic void restart_shadow();
        row_in = 0; col_in = 0; row_out = 0; col_out = 0; frame_in = 0;
    endfunction

    // apply one beat to the shadow; push the median it releases, if any
    function automatic void step_shadow(t_in_beat b);
        int r, w, h, lr, lc, y0, y1, x0, x1, n, acc;
        int hist[256];
        bit re, fe;
        t_out_beat res;
        r = sh_radius;
        w = (sh_width == 0) ? 1 : (sh_width > MAXW ? MAXW : sh_width);
        h = (sh_height == 0) ? 1 : (sh_height > MAX_HEIGHT ? MAX_HEIGHT : sh_height);
        if (b.req_type == REQ_PIXEL && !frame_in) begin
            line_mem[row_in % RING][col_in] = b.pixel_in;
            if (col_in + 1 >= w) begin
                col_in = 0;
                if (row_in + 1 >= h) begin
                    row_in = 0;
                    frame_in = 1;
                end else begin
                    row_in++;
                end
            end else begin
                col_in++;
            end
        end
        lr = (row_out + r > h - 1) ? h - 1 : row_out + r;
        lc = (col_out + r > w - 1) ? w - 1 : col_out + r;
        if (!(frame_in || row_in > lr || (row_in == lr && col_in > lc)))
            return;
        y0 = (row_out - r < 0) ? 0 : row_out - r;
        x0 = (col_out - r < 0) ? 0 : col_out - r;
        y1 = lr;
        x1 = lc;
        foreach (hist[v]) hist[v] = 0;
        n = 0;
        for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++) begin
                hist[line_mem[y % RING][x]]++;
                n++;
            end
        acc = 0;
        res.pixel_out = 8'd0;
        for (int v = 0; v < 256; v++) begin
            acc += hist[v];
            if (acc > n / 2) begin
                res.pixel_out = 8'(v);
                break;
            end
        end
        re = (col_out + 1 >= w);
        fe = re && (row_out + 1 >= h);
        res.row_end = re;
        res.frame_end = fe;
        median_q.push_back(res);
        if (fe) restart_shadow();
        else if (re) begin
            col_out = 0;
            row_out++;
        end else begin
            col_out++;
        end
    endfunction

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                step_shadow(i_in_data);
                beats_owed--;
            end
            if (!i_in_valid || o_in_ready) begin
                if (beat_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= beat_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall);
            if (o_out_valid && i_out_ready) begin
                if (median_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, o_out_data);
                    failed = 1;
                end else begin
                    t_out_beat e;
                    e = median_q.pop_front();
                    if (e.pixel_out != o_out_data.pixel_out ||
                        e.row_end != o_out_data.row_end ||
                        e.frame_end != o_out_data.frame_end) begin
                        $display("%0t: expected %p actual %p", $time, e, o_out_data);
                        failed = 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_beat(logic kind, logic [7:0] px);
        t_in_beat b;
        b.req_type = kind;
        b.pixel_in = px;
        beat_q.push_back(b);
        beats_owed++;
        items++;
    endtask

    task automatic wait_idle();
        while (beats_owed != 0 || median_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS: sh_radius = val & 3;
            CFG_WIDTH:  sh_width  = val & 11'h7ff;
            default:    sh_height = val & 13'h1fff;
        endcase
        restart_shadow();
    endtask

    task automatic configure(int r, int w, int h);
        wait_idle();
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // a frame with a sprinkle of drain ticks, then drains and stray pixels
    task automatic send_frame(int npix, int ndrain);
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(9) == 0) push_beat(REQ_DRAIN, rand_pixel());
            push_beat(REQ_PIXEL, rand_pixel());
        end
        for (int k = 0; k < ndrain; k++)
            push_beat($urandom_range(5) == 0 ? REQ_PIXEL : REQ_DRAIN, rand_pixel());
    endtask

    initial begin
        int r, w, h, we, he, np, phase;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_out_ready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_RADIUS;
        i_cfg_data = '0;
        cycles = 0; failed = 0; beats_owed = 0; items = 0;
        send_idle = 0; recv_stall = 0;
        sh_radius = 1; sh_width = 640; sh_height = 480;
        restart_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single pixel, zero sizes, pass-through, extremes, wide radius
        configure(0, 1, 1);
        push_beat(REQ_PIXEL, 8'd255);
        push_beat(REQ_DRAIN, 8'd0);
        configure(0, 0, 0);
        push_beat(REQ_PIXEL, 8'd0);
        push_beat(REQ_PIXEL, 8'd17);
        configure(1, 3, 3);
        for (int k = 0; k < 5; k++) push_beat(REQ_PIXEL, (k % 2) ? 8'd255 : 8'd0);
        // hold off until every released median is back, then finish the frame
        wait_idle();
        for (int k = 0; k < 4; k++) push_beat(REQ_PIXEL, 8'($urandom_range(255)));
        for (int k = 0; k < 6; k++) push_beat(REQ_DRAIN, 8'd0);
        configure(3, 2, 2);
        send_frame(4, 4);

        // random frames over the idling phases
        phase = 0;
        while (items < 1350) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            r = $urandom_range(3);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            case ($urandom_range(15))
                0: w = 2047;
                1: h = 8191;
                2: w = 0;
                3: h = 0;
                4: w = 1024;
                default: ;
            endcase
            we = (w == 0) ? 1 : (w > MAXW ? MAXW : w);
            he = (h == 0) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
            np = we * he;
            configure(r, w, h);
            if (np > 300) begin
                // too big for a whole frame: feed part and abort on next write
                send_frame(120, 3);
            end else begin
                send_frame(np, (r + 1) * we + r + 4);
            end
            phase++;
        end

        wait_idle();
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
design/cwmf_pkg.sv
design/cwmf_cell.sv
design/cwmf_chain.sv
design/clipped_window_median_filter.sv
bench/clipped_window_median_filter_tb.sv
